>>> sv/oginf_pkg.sv
// ----------------------------------------------------------------------------
// Obstacle inflation package
// Widths, cell codes and shared types of the occupancy grid inflation block.
// ----------------------------------------------------------------------------
package oginf_pkg;

    localparam int MAX_SIDE = 256;
    localparam int COORD_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int CELL_W   = 2;

    typedef logic [CELL_W-1:0]  cell_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIDE_W-1:0]  side_t;

    localparam cell_t CELL_UNKNOWN  = 2'd0;
    localparam cell_t CELL_OCCUPIED = 2'd1;

    localparam logic ACTION_FLUSH = 1'b1;

    localparam side_t SIDE_RESET = side_t'(MAX_SIDE);

    // How far the input position is into the map: results start on the second row.
    typedef enum logic [1:0] {
        ROW_FIRST,
        ROW_SECOND,
        ROW_BODY
    } row_phase_t;

    // One line buffer entry: occupied flag of the row two above, value of the row above.
    typedef struct packed {
        logic  up_occ;
        cell_t mid;
    } line_entry_t;

endpackage

>>> sv/oginf_in_if.sv
// ----------------------------------------------------------------------------
// Cell input channel
// Valid/ready channel that carries one raster map cell or flush pad per beat.
// ----------------------------------------------------------------------------
interface oginf_in_if;
    import oginf_pkg::*;

    logic  valid;
    logic  ready;
    logic  action;
    cell_t cell_in;

    modport source (output valid, output action, output cell_in, input ready);
    modport sink   (input valid, input action, input cell_in, output ready);

endinterface

>>> sv/oginf_out_if.sv
// ----------------------------------------------------------------------------
// Inflated cell output channel
// Valid/ready channel that carries one inflated cell and its position per beat.
// ----------------------------------------------------------------------------
interface oginf_out_if;
    import oginf_pkg::*;

    logic   valid;
    logic   ready;
    cell_t  cell_out;
    coord_t row;
    coord_t col;
    logic   last;

    modport source (output valid, output cell_out, output row, output col, output last,
                    input ready);
    modport sink   (input valid, input cell_out, input row, input col, input last,
                    output ready);

endinterface

>>> sv/occupancy_grid_obstacle_inflate_unit.sv
// ----------------------------------------------------------------------------
// Occupancy grid obstacle inflation
// 3x3 dilation of occupied cells in a raster stream with a two-row line buffer.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  ----------+-----+--------------------------------------------
//  in_chan   | in  | action, cell_in (one map cell or flush pad)
//  out_chan  | out | cell_out, row, col, last
//  cfg_wr_*  | in  | grid_side, written while idle
//
// One cell per clock outside side writes: a beat is taken whenever the result
// register is empty or drained in the same cycle, and its result lands there.
// The line buffer is one memory with a single write and a prefetched,
// registered read of the next column, so it sets no limit below one per cycle.
// Results trail inputs by one row plus one cell; a stalled output holds input.
// Reset clears positions and the window; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_inflate_unit (
    input  logic              clk,
    input  logic              rst_n,
    oginf_in_if.sink          in_chan,
    oginf_out_if.source       out_chan,
    input  logic              cfg_wr_en,
    input  oginf_pkg::side_t  cfg_wr_data
);
    import oginf_pkg::*;

    side_t       side_reg, side_next;
    coord_t      in_col_reg, in_col_next;
    row_phase_t  row_phase_reg, row_phase_next;
    coord_t      out_row_reg, out_row_next;
    coord_t      out_col_reg, out_col_next;

    cell_t       win_reg [2][3];
    cell_t       win_cur [3][3];

    line_entry_t line_mem [MAX_SIDE];
    line_entry_t line_rd_reg;
    line_entry_t wr_entry;

    logic        out_valid_reg;
    cell_t       cell_out_reg;
    coord_t      row_reg;
    coord_t      col_reg;
    logic        last_reg;

    logic        in_ready;
    logic        step;
    cell_t       cell_v;
    logic        in_col_end;
    logic        out_col_end;
    logic        out_row_end;
    logic        emit;
    logic        last;
    logic        occ;
    logic        col_ok [3];
    logic        row_ok [3];

    assign in_ready      = (!out_valid_reg || out_chan.ready) && !cfg_wr_en;
    assign in_chan.ready = in_ready;
    assign step          = in_chan.valid && in_ready;

    // A flush pad stands for an unknown cell wherever it lands.
    assign cell_v = (in_chan.action == ACTION_FLUSH) ? CELL_UNKNOWN : in_chan.cell_in;

    assign in_col_end  = (SIDE_W'(in_col_reg) + SIDE_W'(1)) >= side_reg;
    assign out_col_end = (SIDE_W'(out_col_reg) + SIDE_W'(1)) >= side_reg;
    assign out_row_end = (SIDE_W'(out_row_reg) + SIDE_W'(1)) >= side_reg;
    assign last        = out_row_end && out_col_end;

    assign emit = (row_phase_reg == ROW_BODY)
               || ((row_phase_reg == ROW_SECOND) && (in_col_reg != '0));

    assign wr_entry.up_occ = (line_rd_reg.mid == CELL_OCCUPIED);
    assign wr_entry.mid    = cell_v;

    // Window as it stands once this beat's column has shifted in.
    always_comb
    begin
        for (int dr = 0; dr < 3; dr++)
        begin
            win_cur[0][dr] = win_reg[0][dr];
            win_cur[1][dr] = win_reg[1][dr];
        end
        win_cur[2][0] = cell_t'(line_rd_reg.up_occ);
        win_cur[2][1] = line_rd_reg.mid;
        win_cur[2][2] = cell_v;
    end

    always_comb
    begin
        col_ok[0] = (out_col_reg != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = !out_col_end;
        row_ok[0] = (out_row_reg != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = !out_row_end;
    end

    // The upper row only carries an occupied flag in bit zero.
    always_comb
    begin
        occ = 1'b0;
        for (int dc = 0; dc < 3; dc++)
        begin
            for (int dr = 0; dr < 3; dr++)
            begin
                if (col_ok[dc] && row_ok[dr])
                begin
                    if (dr == 0)
                        occ = occ | win_cur[dc][0][0];
                    else
                        occ = occ | (win_cur[dc][dr] == CELL_OCCUPIED);
                end
            end
        end
    end

    always_comb
    begin
        side_next      = side_reg;
        in_col_next    = in_col_reg;
        row_phase_next = row_phase_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == '0)
                side_next = SIDE_W'(1);
            else if (cfg_wr_data > SIDE_W'(MAX_SIDE))
                side_next = SIDE_W'(MAX_SIDE);
            else
                side_next = cfg_wr_data;
            in_col_next    = '0;
            row_phase_next = ROW_FIRST;
            out_row_next   = '0;
            out_col_next   = '0;
        end
        else if (step)
        begin
            if (in_col_end)
            begin
                in_col_next    = '0;
                row_phase_next = (row_phase_reg == ROW_FIRST) ? ROW_SECOND : ROW_BODY;
            end
            else
            begin
                in_col_next = in_col_reg + COORD_W'(1);
            end
            if (emit)
            begin
                if (last)
                begin
                    in_col_next    = '0;
                    row_phase_next = ROW_FIRST;
                    out_row_next   = '0;
                    out_col_next   = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + COORD_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg      <= SIDE_RESET;
            in_col_reg    <= '0;
            row_phase_reg <= ROW_FIRST;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            for (int dc = 0; dc < 2; dc++)
            begin
                for (int dr = 0; dr < 3; dr++)
                    win_reg[dc][dr] <= '0;
            end
        end
        else
        begin
            side_reg      <= side_next;
            in_col_reg    <= in_col_next;
            row_phase_reg <= row_phase_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            if (step)
            begin
                for (int dr = 0; dr < 3; dr++)
                begin
                    win_reg[0][dr] <= win_cur[1][dr];
                    win_reg[1][dr] <= win_cur[2][dr];
                end
            end
        end
    end

    // The read always fetches the entry for the next input column. When the
    // next column is the one written now, the written entry is forwarded.
    always_ff @(posedge clk)
    begin
        if (step)
            line_mem[in_col_reg] <= wr_entry;
        if (step && (in_col_next == in_col_reg))
            line_rd_reg <= wr_entry;
        else
            line_rd_reg <= line_mem[in_col_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= emit;
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            cell_out_reg <= occ ? CELL_OCCUPIED : win_cur[1][1];
            row_reg      <= out_row_reg;
            col_reg      <= out_col_reg;
            last_reg     <= last;
        end
    end

    assign out_chan.valid    = out_valid_reg;
    assign out_chan.cell_out = cell_out_reg;
    assign out_chan.row      = row_reg;
    assign out_chan.col      = col_reg;
    assign out_chan.last     = last_reg;

    a_in_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        SIDE_W'(in_col_reg) < side_reg)
        else $error("input column outside the map");

    a_out_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        SIDE_W'(out_col_reg) < side_reg && SIDE_W'(out_row_reg) < side_reg)
        else $error("result position outside the map");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit && last |=> in_col_reg == '0 && row_phase_reg == ROW_FIRST
                                 && out_row_reg == '0 && out_col_reg == '0)
        else $error("positions not cleared after the final cell");

    a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_chan.valid && in_ready))
        else $error("result appeared without an input beat");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Obstacle inflation testbench
// Streams raster maps of several sides through the inflation unit, predicts
// every inflated cell with a behavioral line-buffer model and compares each
// output beat field by field, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import oginf_pkg::*;

    localparam logic  ACTION_CELL   = 1'b0;
    localparam cell_t CELL_FREE     = 2'd2;
    localparam cell_t CELL_SPARE    = 2'd3;

    localparam int unsigned RANDOM_ITEMS  = 330;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_IDLE_MAX = 24;
    // Roughly every item ever sent, each waiting out the longest gap on both sides.
    localparam int unsigned ITEM_BOUND    = 2000;
    localparam int unsigned RUN_LIMIT     = ITEM_BOUND * (2 * LONG_IDLE_MAX + 2) * 3;

    localparam int MANGLE_NONE     = 0;
    localparam int MANGLE_ACTION   = 1;
    localparam int MANGLE_TRUNCATE = 2;

    typedef struct packed {
        cell_t  cell_val;
        coord_t row;
        coord_t col;
        logic   last;
    } grid_result_t;

    typedef struct {
        bit    hold;
        logic  action;
        cell_t cell_val;
    } feed_item_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_wr_en;
    side_t cfg_wr_data;

    oginf_in_if  in_if ();
    oginf_out_if out_if ();

    occupancy_grid_obstacle_inflate_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_chan     (in_if),
        .out_chan    (out_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Behavioral model of the inflation window.
    side_t       side_cfg;
    logic        up_line [MAX_SIDE];
    cell_t       mid_line [MAX_SIDE];
    cell_t       win [3][3];   // [column: oldest .. newest][row: upper .. lower]
    int unsigned in_r, in_c, out_r, out_c;

    feed_item_t   cell_feed_q [$];
    grid_result_t inflated_q [$];

    bit          in_taken = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0, send_stretch = 0;
    int unsigned recv_gap = 0, recv_stretch = 0;
    bit          send_calm = 1'b0, recv_calm = 1'b0;

    function automatic int unsigned span_of(input side_t value);
        if (value == 0)
            return 1;
        if (value > MAX_SIDE)
            return MAX_SIDE;
        return value;
    endfunction

    function automatic void restart_positions();
        in_r  = 0;
        in_c  = 0;
        out_r = 0;
        out_c = 0;
    endfunction

    function automatic void inflate_cell(input logic action, input cell_t cell_in,
                                         output bit emits, output grid_result_t res);
        int unsigned span, c, r;
        int          dc, dr;
        cell_t       v, mid;
        logic        up;
        bit          occ;
        span = span_of(side_cfg);
        c = in_c;
        r = in_r;
        v = (action == ACTION_FLUSH) ? CELL_UNKNOWN : cell_in;
        up = up_line[c];
        mid = mid_line[c];
        up_line[c] = (mid == CELL_OCCUPIED);
        mid_line[c] = v;
        for (dc = 0; dc < 2; dc++)
            for (dr = 0; dr < 3; dr++)
                win[dc][dr] = win[dc + 1][dr];
        win[2][0] = {1'b0, up};
        win[2][1] = mid;
        win[2][2] = v;
        emits = (r >= 2) || (r == 1 && c >= 1);
        if (c + 1 >= span)
        begin
            in_c = 0;
            in_r = r + 1;
        end
        else
            in_c = c + 1;
        res = '0;
        if (!emits)
            return;
        // Neighbors that fall outside the map border are skipped.
        occ = 1'b0;
        for (dc = 0; dc < 3; dc++)
        begin
            if ((dc == 0 && out_c == 0) || (dc == 2 && out_c + 1 >= span))
                continue;
            for (dr = 0; dr < 3; dr++)
            begin
                if ((dr == 0 && out_r == 0) || (dr == 2 && out_r + 1 >= span))
                    continue;
                if (dr == 0)
                    occ = occ | win[dc][0][0];
                else if (win[dc][dr] == CELL_OCCUPIED)
                    occ = 1'b1;
            end
        end
        res.cell_val = occ ? CELL_OCCUPIED : win[1][1];
        res.row      = coord_t'(out_r);
        res.col      = coord_t'(out_c);
        res.last     = (out_r + 1 >= span) && (out_c + 1 >= span);
        if (res.last)
            restart_positions();
        else if (out_c + 1 >= span)
        begin
            out_c = 0;
            out_r = out_r + 1;
        end
        else
            out_c = out_c + 1;
    endfunction

    function automatic int unsigned pick_idle(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, LONG_IDLE_MAX);
    endfunction

    function automatic cell_t pick_cell(input int unsigned occ_pct);
        if ($urandom_range(0, 99) < occ_pct)
            return CELL_OCCUPIED;
        case ($urandom_range(0, 2))
            0: return CELL_UNKNOWN;
            1: return CELL_FREE;
            default: return CELL_SPARE;
        endcase
    endfunction

    task automatic push_item(input logic action, input cell_t cell_val);
        feed_item_t item;
        item.hold     = 1'b0;
        item.action   = action;
        item.cell_val = cell_val;
        cell_feed_q.push_back(item);
    endtask

    task automatic push_hold();
        feed_item_t item;
        item.hold     = 1'b1;
        item.action   = ACTION_CELL;
        item.cell_val = CELL_UNKNOWN;
        cell_feed_q.push_back(item);
    endtask

    // A span x span map and its span+1 flush pads unless mangled; returns the beat count.
    task automatic push_map(input int unsigned span, input int unsigned occ_pct,
                            input int mangle, output int unsigned pushed);
        int unsigned total, k;
        logic        action;
        total = span * span + span + 1;
        if (mangle == MANGLE_TRUNCATE)
            total = total - $urandom_range(1, span);
        for (k = 0; k < total; k++)
        begin
            action = (k < span * span) ? ACTION_CELL : ACTION_FLUSH;
            if (mangle == MANGLE_ACTION && $urandom_range(0, 15) == 0)
                action = ~action;
            push_item(action, pick_cell(occ_pct));
        end
        pushed = total;
    endtask

    task automatic settle();
        while (cell_feed_q.size() != 0 || in_if.valid || inflated_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_side(input side_t value);
        settle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        side_cfg = value;
        restart_positions();
    endtask

    // Input side: present the next queued beat once the current one is taken.
    always @(negedge clk)
    begin : cell_driver
        feed_item_t item;
        if (send_stretch == 0)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_stretch = $urandom_range(50, 400);
        end
        else
            send_stretch = send_stretch - 1;
        if (rst_n && (!in_if.valid || in_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap = send_gap - 1;
                in_if.valid <= 1'b0;
            end
            else if (cell_feed_q.size() != 0 && cell_feed_q[0].hold)
            begin
                // Hold the stream until every predicted result has been seen.
                in_if.valid <= 1'b0;
                if (inflated_q.size() == 0)
                    void'(cell_feed_q.pop_front());
            end
            else if (cell_feed_q.size() != 0)
            begin
                item = cell_feed_q.pop_front();
                in_if.valid   <= 1'b1;
                in_if.action  <= item.action;
                in_if.cell_in <= item.cell_val;
                send_gap = pick_idle(send_calm);
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // Output side: random back-pressure.
    always @(negedge clk)
    begin
        if (recv_stretch == 0)
        begin
            recv_calm = ($urandom_range(0, 3) == 0);
            recv_stretch = $urandom_range(50, 400);
        end
        else
            recv_stretch = recv_stretch - 1;
        if (rst_n)
        begin
            if (recv_gap != 0)
            begin
                recv_gap = recv_gap - 1;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
                recv_gap = pick_idle(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin : grid_monitor
        grid_result_t predicted, want;
        bit           emits;
        in_taken <= in_if.valid && in_if.ready;
        if (in_if.valid && in_if.ready)
        begin
            inflate_cell(in_if.action, in_if.cell_in, emits, predicted);
            if (emits)
                inflated_q.push_back(predicted);
        end
        if (out_if.valid && out_if.ready)
        begin
            if (inflated_q.size() == 0)
            begin
                $error("unexpected beat at row %0d col %0d", out_if.row, out_if.col);
                fail_count++;
            end
            else
            begin
                want = inflated_q.pop_front();
                if (out_if.cell_out !== want.cell_val)
                begin
                    $error("cell_out: expected %0d, actual %0d", want.cell_val,
                           out_if.cell_out);
                    fail_count++;
                end
                if (out_if.row !== want.row)
                begin
                    $error("row: expected %0d, actual %0d", want.row, out_if.row);
                    fail_count++;
                end
                if (out_if.col !== want.col)
                begin
                    $error("col: expected %0d, actual %0d", want.col, out_if.col);
                    fail_count++;
                end
                if (out_if.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, out_if.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned sent, pushed, span, occ_pct, maps, roll, m, k;
        int          mangle;
        bit          held;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_if.valid   = 1'b0;
        in_if.action  = ACTION_CELL;
        in_if.cell_in = CELL_UNKNOWN;
        out_if.ready  = 1'b0;
        side_cfg = SIDE_RESET;
        restart_positions();
        for (k = 0; k < MAX_SIDE; k++)
        begin
            up_line[k]  = 1'b0;
            mid_line[k] = CELL_UNKNOWN;
        end
        for (k = 0; k < 9; k++)
            win[k / 3][k % 3] = CELL_UNKNOWN;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 map with two occupied corners, every cell value, pads carrying junk.
        write_side(side_t'(3));
        push_item(ACTION_CELL, CELL_OCCUPIED);  push_item(ACTION_CELL, CELL_FREE);
        push_item(ACTION_CELL, CELL_UNKNOWN);   push_item(ACTION_CELL, CELL_SPARE);
        push_item(ACTION_CELL, CELL_FREE);      push_item(ACTION_CELL, CELL_FREE);
        push_item(ACTION_CELL, CELL_FREE);      push_item(ACTION_CELL, CELL_UNKNOWN);
        push_item(ACTION_CELL, CELL_OCCUPIED);  push_item(ACTION_FLUSH, CELL_SPARE);
        push_item(ACTION_FLUSH, CELL_UNKNOWN);  push_item(ACTION_FLUSH, CELL_OCCUPIED);
        push_item(ACTION_FLUSH, CELL_FREE);
        // 2x2 map: a pad where a cell is due, and a cell where a pad is due.
        write_side(side_t'(2));
        push_item(ACTION_CELL, CELL_SPARE);     push_item(ACTION_FLUSH, CELL_OCCUPIED);
        push_item(ACTION_CELL, CELL_FREE);      push_item(ACTION_CELL, CELL_SPARE);
        push_item(ACTION_CELL, CELL_OCCUPIED);  push_item(ACTION_FLUSH, CELL_FREE);
        push_item(ACTION_FLUSH, CELL_UNKNOWN);
        // A zero side behaves as a single-cell map.
        write_side(side_t'(0));
        push_item(ACTION_CELL, CELL_OCCUPIED);  push_item(ACTION_FLUSH, CELL_SPARE);
        push_item(ACTION_FLUSH, CELL_UNKNOWN);

        // An oversized side is clipped to the largest map; one row and a few cells.
        write_side(side_t'(511));
        for (k = 0; k < MAX_SIDE + 16; k++)
            push_item(ACTION_CELL, pick_cell(3));

        sent = 0;
        held = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                span = 0;
            else if (roll < 36)
                span = $urandom_range(1, 3);
            else if (roll < 90)
                span = $urandom_range(4, 12);
            else
                span = $urandom_range(13, 18);
            write_side(side_t'(span));
            maps = $urandom_range(1, 3);
            for (m = 0; m < maps && sent < RANDOM_ITEMS; m++)
            begin
                case ($urandom_range(0, 4))
                    0: occ_pct = 0;
                    1: occ_pct = 5;
                    2: occ_pct = 15;
                    3: occ_pct = 40;
                    default: occ_pct = 90;
                endcase
                roll = $urandom_range(0, 9);
                mangle = (roll == 0) ? MANGLE_ACTION :
                         (roll == 1) ? MANGLE_TRUNCATE : MANGLE_NONE;
                push_map(span_of(side_t'(span)), occ_pct, mangle, pushed);
                sent = sent + pushed;
                if (!held && sent >= RANDOM_ITEMS / 3)
                begin
                    push_hold();
                    held = 1'b1;
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
